@@ hw/rtl/bpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants and codes of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int NUM_FRAMES_DEF = 65536;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 28;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 17;
  localparam int REG_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_STOP  = 2'd2;

  localparam logic [REG_W-1:0] LOW_RESERVED_RST = 17'd256;

endpackage

@@ hw/rtl/bpfa_map_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_map_ram
// Used-bit map storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpfa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bpfa_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [bpfa_pkg::WORD_BITS-1:0] rdata
);

  logic [bpfa_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bpfa_word_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_word_builder
// Builds the initial used-bit word of one map row from the frame bounds.
// ----------------------------------------------------------------------------
module bpfa_word_builder #(
  parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF,
  parameter int WW         = 10,
  parameter int CNTW       = 17
) (
  input  logic [WW-1:0]                  word_idx,
  input  logic [CNTW-1:0]                lo,
  input  logic [CNTW-1:0]                ks,
  input  logic [CNTW-1:0]                ke,
  output logic [bpfa_pkg::WORD_BITS-1:0] used_word
);

  localparam int BW   = WW + bpfa_pkg::BIT_W;
  localparam int CMPW = ((BW > CNTW) ? BW : CNTW) + 1;

  // bits of the row whose frame index lies below x
  function automatic logic [bpfa_pkg::WORD_BITS-1:0] lt_mask(
    input logic [CMPW-1:0] x,
    input logic [CMPW-1:0] base
  );
    logic [CMPW-1:0] d;
    logic [bpfa_pkg::WORD_BITS-1:0] m;
    d = x - base;
    if (x <= base) begin
      m = '0;
    end else if (d >= CMPW'(bpfa_pkg::WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~({bpfa_pkg::WORD_BITS{1'b1}} << d[bpfa_pkg::BIT_W-1:0]);
    end
    return m;
  endfunction

  logic [CMPW-1:0] base;

  assign base = CMPW'({word_idx, {bpfa_pkg::BIT_W{1'b0}}});

  assign used_word = lt_mask(CMPW'(lo), base)
                   | ~lt_mask(CMPW'(NUM_FRAMES), base)
                   | (lt_mask(CMPW'(ke), base) & ~lt_mask(CMPW'(ks), base));

endmodule

@@ hw/rtl/bitmap_page_frame_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; one result follows,
// shown for a single cycle with out_valid, and the receiver cannot stall it.
// The map lives in one memory of (NUM_FRAMES+63)/64 rows of 64 bits with one
// write and one read port, and that port sets the rate. Init writes one row a
// cycle over all rows; alloc reads one row a cycle and scans rows up to and
// including the first row with a free frame, or all rows when the map is
// full; free reads the addressed row in S_FREE_RD and clears the bit, if set,
// in S_FREE_WR; no-op items and items rejected before init or for an
// out-of-range address are answered from the idle state. The result is
// shown in the first cycle in which busy is low again, and a new item may be
// started in that same cycle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit #(
  parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bpfa_pkg::KIND_W-1:0]     in_kind,
  input  logic [bpfa_pkg::ADDR_W-1:0]     in_free_address,
  output logic                            out_valid,
  output logic [bpfa_pkg::ADDR_W-1:0]     out_frame_address,
  output logic [bpfa_pkg::STATUS_W-1:0]   out_status,
  output logic [bpfa_pkg::COUNT_W-1:0]    out_free_count,
  input  logic                            cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpfa_pkg::REG_W-1:0]      cfg_wdata
);

  localparam int MAP_WORDS  = (NUM_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int WW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNTW       = $clog2(NUM_FRAMES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int AFW        = bpfa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int FRW        = WW + bpfa_pkg::BIT_W;
  localparam int ACW        = (FRW + PAGE_SHIFT > bpfa_pkg::ADDR_W) ?
                              FRW + PAGE_SHIFT : bpfa_pkg::ADDR_W;
  localparam int OCW        = (CNTW > bpfa_pkg::COUNT_W) ? CNTW : bpfa_pkg::COUNT_W;
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_FREE_RD = 3'd3;
  localparam logic [2:0] S_FREE_WR = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [WW-1:0]                cnt_r, cnt_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [WW-1:0]                rd_widx_r, rd_widx_nxt;
  logic [WW-1:0]                fr_widx_r, fr_widx_nxt;
  logic [bpfa_pkg::BIT_W-1:0]   fr_bit_r, fr_bit_nxt;
  logic                         initialized_r, initialized_nxt;
  logic [CNTW-1:0]              free_total_r, free_total_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [bpfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bpfa_pkg::COUNT_W-1:0] out_count_r;
  logic [bpfa_pkg::REG_W-1:0]   cfg_lo_r, cfg_ks_r, cfg_ke_r;

  logic [CNTW-1:0] lo_c, ks_c, ke_c, ovl_lo, ovl, init_free;
  logic [bpfa_pkg::WORD_BITS-1:0] init_word;

  logic                           ram_we;
  logic [WW-1:0]                  ram_waddr, ram_raddr;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [bpfa_pkg::WORD_BITS-1:0] zero_onehot;
  logic [bpfa_pkg::BIT_W-1:0]     zero_idx;
  logic [FRW-1:0]                 alloc_frame;
  logic [ACW-1:0]                 alloc_addr;

  logic [AFW-1:0] fr_frame, fr_word_full;
  logic           fr_range_bad;
  logic [OCW-1:0] count_ext;

  // bounds saturated to the map size
  assign lo_c = (32'(cfg_lo_r) > 32'(NUM_FRAMES)) ? CNTW'(NUM_FRAMES) : CNTW'(cfg_lo_r);
  assign ks_c = (32'(cfg_ks_r) > 32'(NUM_FRAMES)) ? CNTW'(NUM_FRAMES) : CNTW'(cfg_ks_r);
  assign ke_c = (32'(cfg_ke_r) > 32'(NUM_FRAMES)) ? CNTW'(NUM_FRAMES) : CNTW'(cfg_ke_r);

  // kernel frames that fall inside the freed range
  assign ovl_lo    = (ks_c > lo_c) ? ks_c : lo_c;
  assign ovl       = (ke_c > ovl_lo) ? (ke_c - ovl_lo) : '0;
  assign init_free = CNTW'(NUM_FRAMES) - lo_c - ovl;

  bpfa_word_builder #(
    .NUM_FRAMES (NUM_FRAMES),
    .WW         (WW),
    .CNTW       (CNTW)
  ) u_word_builder (
    .word_idx  (cnt_r),
    .lo        (lo_c),
    .ks        (ks_c),
    .ke        (ke_c),
    .used_word (init_word)
  );

  bpfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // lowest free frame in the row just read
  assign zero_onehot = ~ram_rdata & (ram_rdata + 64'd1);

  always_comb begin
    zero_idx = '0;
    for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
      if (zero_onehot[j]) begin
        zero_idx = zero_idx | bpfa_pkg::BIT_W'(j);
      end
    end
  end

  assign alloc_frame = {rd_widx_r, zero_idx};
  assign alloc_addr  = ACW'(alloc_frame) << PAGE_SHIFT;

  assign fr_frame     = in_free_address[bpfa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign fr_word_full = fr_frame >> bpfa_pkg::BIT_W;
  assign fr_range_bad = (32'(fr_frame) >= 32'(NUM_FRAMES));

  assign ram_raddr = (state_r == S_SCAN) ? cnt_r : fr_widx_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = rd_vld_r;
    rd_widx_nxt     = rd_widx_r;
    fr_widx_nxt     = fr_widx_r;
    fr_bit_nxt      = fr_bit_r;
    initialized_nxt = initialized_r;
    free_total_nxt  = free_total_r;
    out_valid_nxt   = 1'b0;
    out_addr_nxt    = '0;
    out_status_nxt  = bpfa_pkg::ST_OK;
    ram_we          = 1'b0;
    ram_waddr       = cnt_r;
    ram_wdata       = init_word;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_kind)
            bpfa_pkg::KIND_INIT: begin
              cnt_nxt   = '0;
              state_nxt = S_INIT;
            end
            bpfa_pkg::KIND_ALLOC: begin
              if (!initialized_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bpfa_pkg::ST_NOT_INIT;
              end else begin
                cnt_nxt    = '0;
                rd_vld_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            bpfa_pkg::KIND_FREE: begin
              if (!initialized_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bpfa_pkg::ST_NOT_INIT;
              end else if (fr_range_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bpfa_pkg::ST_RANGE;
              end else begin
                fr_widx_nxt = WW'(fr_word_full);
                fr_bit_nxt  = fr_frame[bpfa_pkg::BIT_W-1:0];
                state_nxt   = S_FREE_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = init_word;
        if (cnt_r == LAST_WORD) begin
          free_total_nxt  = init_free;
          initialized_nxt = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_SCAN: begin
        rd_vld_nxt  = 1'b1;
        rd_widx_nxt = cnt_r;
        if (cnt_r != LAST_WORD) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (ram_rdata != '1) begin
            ram_we         = 1'b1;
            ram_waddr      = rd_widx_r;
            ram_wdata      = ram_rdata | zero_onehot;
            free_total_nxt = free_total_r - 1'b1;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = alloc_addr[bpfa_pkg::ADDR_W-1:0];
            state_nxt      = S_IDLE;
          end else if (rd_widx_r == LAST_WORD) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bpfa_pkg::ST_NO_FRAME;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end

      S_FREE_WR: begin
        if (ram_rdata[fr_bit_r]) begin
          ram_we         = 1'b1;
          ram_waddr      = fr_widx_r;
          ram_wdata      = ram_rdata & ~(64'd1 << fr_bit_r);
          free_total_nxt = free_total_r + 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = OCW'(free_total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_vld_r      <= 1'b0;
      initialized_r <= 1'b0;
      free_total_r  <= '0;
      out_valid_r   <= 1'b0;
      cfg_lo_r      <= bpfa_pkg::LOW_RESERVED_RST;
      cfg_ks_r      <= '0;
      cfg_ke_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      rd_vld_r      <= rd_vld_nxt;
      initialized_r <= initialized_nxt;
      free_total_r  <= free_total_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bpfa_pkg::CFG_LOW_RESERVED: cfg_lo_r <= cfg_wdata;
          bpfa_pkg::CFG_KERNEL_FIRST: cfg_ks_r <= cfg_wdata;
          bpfa_pkg::CFG_KERNEL_STOP:  cfg_ke_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_widx_r   <= rd_widx_nxt;
    fr_widx_r   <= fr_widx_nxt;
    fr_bit_r    <= fr_bit_nxt;
    if (out_valid_nxt) begin
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_ext[bpfa_pkg::COUNT_W-1:0];
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_count    = out_count_r;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
// Drives init, alloc, free and no-op commands through the start/busy port and
// keeps its own copy of the used-frame map and free count. Every command that
// is taken yields one expected result. Each out_valid transfer is checked
// field by field against the oldest expected result. Directed tests cover
// commands before init, the reset limits, kernel range corners and a full
// map. Random traffic then runs under several limit settings and sender idle
// rates.
// ----------------------------------------------------------------------------
module tb_top;
  import bpfa_pkg::*;

  localparam int MAP_ROWS      = NUM_FRAMES_DEF / WORD_BITS;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 1100;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_ITEMS   = 140;

  typedef struct packed {
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } frame_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind;
  logic [ADDR_W-1:0]    in_free_address;
  logic                 out_valid;
  logic [ADDR_W-1:0]    out_frame_address;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_free_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  // shadow of the allocator state
  logic [WORD_BITS-1:0] frame_rows [0:MAP_ROWS-1];
  bit                   map_ready = 1'b0;
  int                   free_frames = 0;
  logic [REG_W-1:0]     low_reserved = LOW_RESERVED_RST;
  logic [REG_W-1:0]     kernel_first = '0;
  logic [REG_W-1:0]     kernel_stop = '0;

  frame_result_t        pending_results[$];
  frame_result_t        oldest_pending;
  int                   held_frames[$];
  int                   sender_idle_pct = 0;
  int                   mismatch_count = 0;
  int unsigned          cycle_count = 0;

  bitmap_page_frame_allocator_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_frame_address (out_frame_address),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_status, '0);
      end else begin
        oldest_pending = pending_results.pop_front();
        if (out_frame_address !== oldest_pending.frame_address) begin
          report_mismatch("frame_address", out_frame_address, oldest_pending.frame_address);
        end
        if (out_status !== oldest_pending.status) begin
          report_mismatch("status", out_status, oldest_pending.status);
        end
        if (out_free_count !== oldest_pending.free_count) begin
          report_mismatch("free_count", out_free_count, oldest_pending.free_count);
        end
      end
    end
  end

  function automatic int clamp_to_map(input logic [REG_W-1:0] v);
    return (v > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : int'(v);
  endfunction

  // bits of one map row whose frame index is at or above bound
  function automatic logic [WORD_BITS-1:0] bits_from(input int row, input int bound);
    int base;
    base = row * WORD_BITS;
    if (bound <= base) begin
      return '1;
    end
    if (bound >= base + WORD_BITS) begin
      return '0;
    end
    return ~64'd0 << (bound - base);
  endfunction

  task automatic rebuild_frame_map();
    int lo, ks, ke, row;
    logic [WORD_BITS-1:0] kernel_bits, open_bits;
    lo = clamp_to_map(low_reserved);
    ks = clamp_to_map(kernel_first);
    ke = clamp_to_map(kernel_stop);
    free_frames = 0;
    for (row = 0; row < MAP_ROWS; row++) begin
      kernel_bits = bits_from(row, ks) & ~bits_from(row, ke);
      open_bits = bits_from(row, lo) & ~kernel_bits;
      frame_rows[row] = ~open_bits;
      free_frames += $countones(open_bits);
    end
    map_ready = 1'b1;
    held_frames.delete();
  endtask

  task automatic predict_outcome(input logic [KIND_W-1:0] kind,
                                 input logic [ADDR_W-1:0] addr,
                                 output frame_result_t outcome);
    int row, bit_pos, frame_idx;
    bit found;
    outcome.frame_address = '0;
    outcome.status = ST_OK;
    case (kind)
      KIND_INIT: begin
        rebuild_frame_map();
      end
      KIND_ALLOC: begin
        if (!map_ready) begin
          outcome.status = ST_NOT_INIT;
        end else begin
          outcome.status = ST_NO_FRAME;
          found = 1'b0;
          for (row = 0; row < MAP_ROWS && !found; row++) begin
            if (frame_rows[row] != '1) begin
              found = 1'b1;
              bit_pos = 0;
              while (frame_rows[row][bit_pos]) bit_pos++;
              frame_rows[row][bit_pos] = 1'b1;
              free_frames--;
              frame_idx = row * WORD_BITS + bit_pos;
              outcome.frame_address = ADDR_W'(frame_idx * PAGE_BYTES_DEF);
              outcome.status = ST_OK;
              held_frames.push_back(frame_idx);
            end
          end
        end
      end
      KIND_FREE: begin
        if (!map_ready) begin
          outcome.status = ST_NOT_INIT;
        end else begin
          frame_idx = int'(addr / PAGE_BYTES_DEF);
          if (frame_idx >= NUM_FRAMES_DEF) begin
            outcome.status = ST_RANGE;
          end else if (frame_rows[frame_idx / WORD_BITS][frame_idx % WORD_BITS]) begin
            frame_rows[frame_idx / WORD_BITS][frame_idx % WORD_BITS] = 1'b0;
            free_frames++;
          end
        end
      end
      KIND_NOP: ;
    endcase
    outcome.free_count = COUNT_W'(free_frames);
  endtask

  // start stays high between back-to-back commands
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    frame_result_t outcome;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_kind <= KIND_W'($urandom_range(3));
      in_free_address <= ADDR_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_free_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_outcome(kind, addr, outcome);
    pending_results.push_back(outcome);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_frame_limits(input logic [REG_W-1:0] low, input logic [REG_W-1:0] kfirst,
                                   input logic [REG_W-1:0] kend);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOW_RESERVED;
    cfg_wdata <= low;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_FIRST;
    cfg_wdata <= kfirst;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_STOP;
    cfg_wdata <= kend;
    @(posedge clk);
    cfg_we <= 1'b0;
    low_reserved = low;
    kernel_first = kfirst;
    kernel_stop = kend;
    @(posedge clk);
  endtask

  task automatic test_uninitialized();
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, '0);
    send_item(KIND_FREE, '1);
    send_item(KIND_NOP, '1);
  endtask

  // reset limits: low 256 frames reserved, no kernel range
  task automatic test_init_and_alloc();
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, 28'h0100123);
    send_item(KIND_FREE, 28'h0100123);
    send_item(KIND_FREE, '1);
    send_item(KIND_FREE, '0);
    send_item(KIND_ALLOC, '1);
    send_item(KIND_NOP, '0);
  endtask

  task automatic test_kernel_ranges();
    // empty kernel range
    load_frame_limits(17'd0, 17'd100, 17'd50);
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
    // kernel range under the low boundary
    load_frame_limits(17'd1000, 17'd10, 17'd500);
    send_item(KIND_INIT, '0);
    // kernel range straddling the low boundary
    load_frame_limits(17'd256, 17'd200, 17'd1024);
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
  endtask

  task automatic test_full_map();
    load_frame_limits(17'h10000, 17'd0, 17'd0);
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, '1);
    send_item(KIND_ALLOC, '0);
    // limits past the end of the map
    load_frame_limits(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
    load_frame_limits(17'd0, 17'd0, 17'h1FFFF);
    send_item(KIND_INIT, '0);
    send_item(KIND_ALLOC, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input logic [REG_W-1:0] low,
                                     input logic [REG_W-1:0] kfirst,
                                     input logic [REG_W-1:0] kend);
    int n, pick, idx, frame_idx;
    logic [ADDR_W-1:0] addr;
    load_frame_limits(low, kfirst, kend);
    sender_idle_pct = idle_pct;
    send_item(KIND_INIT, ADDR_W'($urandom));
    for (n = 1; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      addr = ADDR_W'($urandom);
      if (pick < 3) begin
        send_item(KIND_INIT, addr);
      end else if (pick < 45 || (pick < 72 && held_frames.size() == 0)) begin
        send_item(KIND_ALLOC, addr);
      end else if (pick < 72) begin
        // return a frame handed out earlier, at a random offset inside it
        idx = $urandom_range(held_frames.size() - 1);
        frame_idx = held_frames[idx];
        held_frames.delete(idx);
        send_item(KIND_FREE, ADDR_W'(frame_idx * PAGE_BYTES_DEF + addr[11:0]));
      end else if (pick < 82) begin
        send_item(KIND_FREE, addr);
      end else if (pick < 94) begin
        send_item(KIND_FREE, ADDR_W'($urandom_range(2047) * PAGE_BYTES_DEF + addr[11:0]));
      end else begin
        send_item(KIND_NOP, addr);
      end
    end
    wait_for_results();
    sender_idle_pct = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_NOP;
    in_free_address <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LOW_RESERVED;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_uninitialized();
    test_init_and_alloc();
    test_kernel_ranges();
    test_full_map();

    test_random_traffic(0, REG_W'($urandom_range(4096)), REG_W'($urandom_range(8192)),
                        REG_W'($urandom_range(12288)));
    test_random_traffic(62, REG_W'($urandom_range(65480, 65536)),
                        REG_W'($urandom_range(65400, 65536)),
                        REG_W'($urandom_range(65400, 65536)));
    test_random_traffic(24, REG_W'($urandom_range(65536)), REG_W'($urandom_range(65536)),
                        REG_W'($urandom_range(65536)));
    test_random_traffic(62, REG_W'($urandom_range(20000)), REG_W'($urandom_range(17'h1FFFF)),
                        REG_W'($urandom_range(17'h1FFFF)));

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bpfa_pkg.sv
hw/rtl/bpfa_map_ram.sv
hw/rtl/bpfa_word_builder.sv
hw/rtl/bitmap_page_frame_allocator_unit.sv
dv/tb_top.sv
